/* design/triangle_tangent_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the triangle tangent block.
// Both macros expect signals named clk and rst in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tritan_pkg.sv */
// ---------------------------------------------------------------------------
// tritan_pkg
// Widths, constants and types shared by the triangle tangent modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tritan_pkg;

  localparam int CoordW   = 16;             // position and texcoord width
  localparam int DeltaW   = CoordW + 1;     // edge and UV delta width
  localparam int InDataW  = 5 * CoordW;     // packed vertex word
  localparam int MulW     = 31;             // shared multiplier operand width
  localparam int ProdW    = 2 * MulW;       // multiplier product width
  localparam int TanW     = 2 * DeltaW + 1; // raw tangent and determinant width
  localparam int NormW    = 30;             // magnitudes are normalized below 2^NormW
  localparam int LeftStep = 8;              // coarse left shift during normalization
  localparam int SumW     = ProdW;          // sum of squares
  localparam int RootW    = SumW / 2;       // integer square root
  localparam int FracBits = 14;             // Q1.14 output
  localparam int QuoW     = FracBits + 1;   // quotient bits
  localparam int OutW     = 16;             // one output component
  localparam int OutDataW = 3 * OutW;       // packed result word

  localparam logic [QuoW-1:0] OneQ14 = QuoW'(1 << FracBits);

  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [MulW-1:0]   mul_op_t;
  typedef logic signed [ProdW-1:0]  mul_prod_t;
  typedef logic signed [TanW-1:0]   tan_t;
  typedef logic        [TanW-1:0]   mag_t;

endpackage

/* design/tritan_mul.sv */
// ---------------------------------------------------------------------------
// tritan_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tritan_mul (
  input  logic                  clk,
  input  tritan_pkg::mul_op_t   a,
  input  tritan_pkg::mul_op_t   b,
  output tritan_pkg::mul_prod_t prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* design/tritan_sqrt.sv */
// ---------------------------------------------------------------------------
// tritan_sqrt
// Iterative integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tritan_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tritan_pkg::SumW-1:0]  s,
  output logic                         done,
  output logic [tritan_pkg::RootW-1:0] root
);
  import tritan_pkg::*;

  localparam int CntW = $clog2(RootW);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [SumW-1:0] sreg;
  logic [RootW:0]  rem;
  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;
  logic            ge;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_sh = {rem, sreg[SumW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(RootW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= s;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sreg <= {sreg[SumW-3:0], 2'b00};
      rem  <= ge ? diff[RootW:0] : rem_sh[RootW:0];
      root <= {root[RootW-2:0], ge};
    end
  end

endmodule

/* design/tritan_div.sv */
// ---------------------------------------------------------------------------
// tritan_div
// Restoring divider for one Q1.14 component, rounded to nearest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tritan_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tritan_pkg::NormW-1:0] num,
  input  logic [tritan_pkg::RootW-1:0] den,
  output logic                         done,
  output logic [tritan_pkg::QuoW-1:0]  quo
);
  import tritan_pkg::*;

  localparam int NumW = NormW + FracBits + 1;
  localparam int CntW = $clog2(QuoW);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [NumW-1:0] n_full;
  logic [RootW-1:0] rem;
  logic [QuoW-1:0] nbits;
  logic [RootW:0]  trial;
  logic [RootW:0]  diff;
  logic            ge;

  // Dividend is num * 2^14 plus half the divisor. The quotient stays below
  // 2^QuoW, so the top bits already form a remainder smaller than den.
  assign n_full = NumW'({num, {FracBits{1'b0}}}) + NumW'(den >> 1);
  assign trial  = {rem, nbits[QuoW-1]};
  assign ge     = (trial >= {1'b0, den});
  assign diff   = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(QuoW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RootW'(n_full[NumW-1:QuoW]);
      nbits <= n_full[QuoW-1:0];
      quo   <= '0;
    end else if (busy) begin
      rem   <= ge ? diff[RootW-1:0] : trial[RootW-1:0];
      nbits <= {nbits[QuoW-2:0], 1'b0};
      quo   <= {quo[QuoW-2:0], ge};
    end
  end

endmodule

/* design/triangle_tangent.sv */
// ---------------------------------------------------------------------------
// triangle_tangent: per-triangle unit tangent from positions and texcoords.
// The bit-serial square root and the three serial divides set most of the
// latency. Vertex words are taken only while the sequencer is idle, so a new
// triangle waits until the last result is in the output register. Degenerate
// triangles skip the root and divides. Synchronous active-high reset clears control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_tangent_assert.svh"

module triangle_tangent (
  input  logic                            clk,
  input  logic                            rst,
  // Vertex words in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [63:48], tex_v [79:64]
  input  logic [tritan_pkg::InDataW-1:0]  s_tdata,
  // Tangent words out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tangent_x [15:0], tangent_y [31:16], tangent_z [47:32]
  output logic [tritan_pkg::OutDataW-1:0] m_tdata,
  // degenerate [0]
  output logic                            m_tuser
);
  import tritan_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // taking vertex words
  localparam logic [2:0] ST_MUL  = 3'd1;  // determinant and raw tangent
  localparam logic [2:0] ST_PREP = 3'd2;  // magnitudes, signs, degenerate check
  localparam logic [2:0] ST_NORM = 3'd3;  // shift magnitudes into range
  localparam logic [2:0] ST_SQ   = 3'd4;  // sum of squares
  localparam logic [2:0] ST_ROOT = 3'd5;  // square root
  localparam logic [2:0] ST_DIV  = 3'd6;  // three divides
  localparam logic [2:0] ST_OUT  = 3'd7;  // hand result to the output register

  // Corner that the next vertex fills.
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  localparam logic [3:0] MulLast = 4'd8;
  localparam logic [3:0] SqLast  = 4'd3;
  localparam logic [3:0] DivLast = 4'd2;

  function automatic delta_t sub16(input logic [CoordW-1:0] a,
                                   input logic [CoordW-1:0] b);
    return delta_t'(signed'(a)) - delta_t'(signed'(b));
  endfunction

  logic [2:0]        state;
  logic [1:0]        slot;
  logic [3:0]        cnt;
  logic              in_acc;

  logic [CoordW-1:0] in_pos [3];
  logic [CoordW-1:0] in_u;
  logic [CoordW-1:0] in_v;
  logic [CoordW-1:0] hold_pos [6];
  logic [CoordW-1:0] hold_tex [4];

  delta_t            e1 [3];
  delta_t            e2 [3];
  delta_t            du1, dv1, du2, dv2;

  mul_op_t           mul_a, mul_b;
  mul_prod_t         prod;
  tan_t              first;
  tan_t              diff;
  tan_t              t [3];
  logic              det_zero, det_neg;
  logic              degen;

  mag_t              mag [3];
  mag_t              mag_or;
  logic [2:0]        flip;
  logic              any_hi, any_top, far_low, norm_done;
  logic [NormW-1:0]  sq_pick;

  logic [SumW-1:0]   sum, sum_next;
  logic              root_start, root_done;
  logic [RootW-1:0]  root_val;

  logic              div_start, div_done;
  logic [1:0]        div_sel;
  logic [NormW-1:0]  div_num;
  logic [QuoW-1:0]   quo, q_sat;
  logic              flip_cur;
  logic [OutW-1:0]   q_mag, q_out;
  logic [OutW-1:0]   tan_out [3];
  logic              deg;

  // -------------------------------------------------------------------------
  // Input side. The block takes vertex words only while the sequencer is
  // idle; the output register lets all three vertices of the next
  // triangle arrive while a finished result still waits downstream.
  // -------------------------------------------------------------------------
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;

  assign in_pos[0] = s_tdata[CoordW-1:0];
  assign in_pos[1] = s_tdata[2*CoordW-1:CoordW];
  assign in_pos[2] = s_tdata[3*CoordW-1:2*CoordW];
  assign in_u      = s_tdata[4*CoordW-1:3*CoordW];
  assign in_v      = s_tdata[5*CoordW-1:4*CoordW];

  // -------------------------------------------------------------------------
  // Shared multiplier. In ST_MUL the even steps issue the first product of a
  // pair and the odd steps the product that is subtracted from it:
  //   det  = du1*dv2 - du2*dv1
  //   t[i] = dv2*e1[i] - dv1*e2[i]
  // In ST_SQ it squares the normalized magnitudes one at a time.
  // -------------------------------------------------------------------------
  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_pick = mag[0][NormW-1:0];
      2'd1:    sq_pick = mag[1][NormW-1:0];
      default: sq_pick = mag[2][NormW-1:0];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL: begin
        case (cnt)
          4'd0: begin mul_a = mul_op_t'(du1); mul_b = mul_op_t'(dv2);   end
          4'd1: begin mul_a = mul_op_t'(du2); mul_b = mul_op_t'(dv1);   end
          4'd2: begin mul_a = mul_op_t'(dv2); mul_b = mul_op_t'(e1[0]); end
          4'd3: begin mul_a = mul_op_t'(dv1); mul_b = mul_op_t'(e2[0]); end
          4'd4: begin mul_a = mul_op_t'(dv2); mul_b = mul_op_t'(e1[1]); end
          4'd5: begin mul_a = mul_op_t'(dv1); mul_b = mul_op_t'(e2[1]); end
          4'd6: begin mul_a = mul_op_t'(dv2); mul_b = mul_op_t'(e1[2]); end
          4'd7: begin mul_a = mul_op_t'(dv1); mul_b = mul_op_t'(e2[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQ: begin
        mul_a = mul_op_t'({{(MulW-NormW){1'b0}}, sq_pick});
        mul_b = mul_op_t'({{(MulW-NormW){1'b0}}, sq_pick});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tritan_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // The products of the first pass fit in TanW bits, so truncation is exact.
  assign diff  = first - tan_t'(prod);
  assign degen = det_zero || ((t[0] == '0) && (t[1] == '0) && (t[2] == '0));

  // -------------------------------------------------------------------------
  // Normalization. The largest magnitude must end up in [2^29, 2^30). Only
  // OR reductions are needed: the high bits of all three magnitudes ORed
  // together tell whether the largest is too big or too small. Far-low
  // vectors take a coarse left step to save cycles; right shifts truncate one
  // bit at a time, which equals one wide truncating shift.
  // -------------------------------------------------------------------------
  assign mag_or    = mag[0] | mag[1] | mag[2];
  assign any_hi    = |mag_or[TanW-1:NormW];
  assign any_top   = |mag_or[TanW-1:NormW-1];
  assign far_low   = ~|mag_or[TanW-1:NormW-1-LeftStep];
  assign norm_done = !any_hi && any_top;

  // -------------------------------------------------------------------------
  // Square root of the sum of squares. The last square is added on the fly
  // so the root starts in the same cycle the sum completes.
  // -------------------------------------------------------------------------
  assign sum_next   = sum + $unsigned(prod);
  assign root_start = (state == ST_SQ) && (cnt == SqLast);

  tritan_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .s     (sum_next),
    .done  (root_done),
    .root  (root_val)
  );

  // -------------------------------------------------------------------------
  // Divides. One divider serves x, y and z in turn; each new divide starts in
  // the cycle the previous one reports done.
  // -------------------------------------------------------------------------
  assign div_start = ((state == ST_ROOT) && root_done) ||
                     ((state == ST_DIV) && div_done && (cnt != DivLast));
  assign div_sel   = (state == ST_ROOT) ? 2'd0 : (cnt[1:0] + 2'd1);

  always_comb begin
    case (div_sel)
      2'd0:    div_num = mag[0][NormW-1:0];
      2'd1:    div_num = mag[1][NormW-1:0];
      default: div_num = mag[2][NormW-1:0];
    endcase
  end

  tritan_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (root_val),
    .done  (div_done),
    .quo   (quo)
  );

  // Clamp to one and apply the sign of the component times the sign of det.
  always_comb begin
    case (cnt[1:0])
      2'd0:    flip_cur = flip[0];
      2'd1:    flip_cur = flip[1];
      default: flip_cur = flip[2];
    endcase
    q_sat = (quo > OneQ14) ? OneQ14 : quo;
    q_mag = OutW'(q_sat);
    q_out = flip_cur ? (-q_mag) : q_mag;
  end

  // -------------------------------------------------------------------------
  // Sequencer and output valid.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot     <= SLOT_A;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The output word is set when the result is handed over and cleared
      // once it is taken with nothing new behind it.
      if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (slot)
              SLOT_B: slot <= SLOT_C;
              SLOT_C: begin
                slot  <= SLOT_A;
                state <= ST_MUL;
                cnt   <= '0;
              end
              default: slot <= SLOT_B;
            endcase
          end
        end
        ST_MUL: begin
          if (cnt == MulLast) begin
            state <= ST_PREP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_PREP: begin
          state <= degen ? ST_OUT : ST_NORM;
        end
        ST_NORM: begin
          if (norm_done) begin
            state <= ST_SQ;
            cnt   <= '0;
          end
        end
        ST_SQ: begin
          if (cnt == SqLast) begin
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (cnt == DivLast) begin
              state <= ST_OUT;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Datapath registers. None of these is read before it is written, so they
  // carry no reset.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Vertex capture. The third vertex is turned into edges and UV deltas
    // right away and never stored itself.
    if (in_acc) begin
      case (slot)
        SLOT_B: begin
          for (int i = 0; i < 3; i++) begin
            hold_pos[3+i] <= in_pos[i];
          end
          hold_tex[2] <= in_u;
          hold_tex[3] <= in_v;
        end
        SLOT_C: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= sub16(hold_pos[3+i], hold_pos[i]);
            e2[i] <= sub16(in_pos[i], hold_pos[i]);
          end
          du1 <= sub16(hold_tex[2], hold_tex[0]);
          dv1 <= sub16(hold_tex[3], hold_tex[1]);
          du2 <= sub16(in_u, hold_tex[0]);
          dv2 <= sub16(in_v, hold_tex[1]);
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            hold_pos[i] <= in_pos[i];
          end
          hold_tex[0] <= in_u;
          hold_tex[1] <= in_v;
        end
      endcase
    end

    // Products arrive in the cycle after issue: odd counts see the first
    // product of a pair, even counts the second.
    if ((state == ST_MUL) && (cnt != '0)) begin
      if (cnt[0]) begin
        first <= tan_t'(prod);
      end else begin
        case (cnt)
          4'd2: begin
            det_zero <= (diff == '0);
            det_neg  <= diff[TanW-1];
          end
          4'd4:    t[0] <= diff;
          4'd6:    t[1] <= diff;
          default: t[2] <= diff;
        endcase
      end
    end

    if (state == ST_PREP) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= t[i][TanW-1] ? mag_t'(-t[i]) : mag_t'(t[i]);
        flip[i] <= t[i][TanW-1] ^ det_neg;
      end
      deg <= degen;
      if (degen) begin
        for (int i = 0; i < 3; i++) begin
          tan_out[i] <= '0;
        end
      end
    end

    if (state == ST_NORM) begin
      for (int i = 0; i < 3; i++) begin
        if (any_hi) begin
          mag[i] <= mag[i] >> 1;
        end else if (far_low) begin
          mag[i] <= mag[i] << LeftStep;
        end else if (!any_top) begin
          mag[i] <= mag[i] << 1;
        end
      end
    end

    if (state == ST_SQ) begin
      sum <= (cnt == '0) ? '0 : sum_next;
    end

    if ((state == ST_DIV) && div_done) begin
      case (cnt[1:0])
        2'd0:    tan_out[0] <= q_out;
        2'd1:    tan_out[1] <= q_out;
        default: tan_out[2] <= q_out;
      endcase
    end

    // Output register: loaded when empty or being emptied this cycle.
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {tan_out[2], tan_out[1], tan_out[0]};
      m_tuser <= deg;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `TT_ASSERT_NXT(a_third_vertex_busy, in_acc && (slot == SLOT_C), !s_tready, "third vertex did not start work")
  `TT_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate result not zero")
  `TT_ASSERT_IMP(a_norm_range, state == ST_SQ, !any_hi && mag_or[NormW-1], "magnitudes not normalized")
  `TT_ASSERT_IMP(a_root_owner, root_done, state == ST_ROOT, "square root finished out of turn")

endmodule
